// ----- hw/rtl/lca_pkg.sv -----
// Shared types and constants for the lowest common ancestor block.
package lca_pkg;

  // Node table size and derived widths
  localparam int MAX_NODES = 1024;
  localparam int ID_W      = 11;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int DEPTH_W   = $clog2(MAX_NODES + 1);

  localparam logic [ID_W-1:0]    MAX_ID    = ID_W'(MAX_NODES);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_NODES);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(MAX_NODES - 1);

  // Input word kinds
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Request from the top level to the query walker
  typedef struct packed {
    logic            start;
    logic            ack;
    logic [ID_W-1:0] node_a;
    logic [ID_W-1:0] node_b;
  } walk_req_t;

  // Status from the query walker
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [ID_W-1:0] result;
  } walk_stat_t;

  // Table address of a node id (ids start at 1)
  function automatic logic [ADDR_W-1:0] node_addr(input logic [ID_W-1:0] node);
    logic [ID_W-1:0] idx;
    idx = node - ID_W'(1);
    return idx[ADDR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/tree_lowest_common_ancestor.sv -----
// Top level of the lowest common ancestor block.
//
// Input channel (in_valid / in_stall): one word per item. in_kind selects
// an edge (in_first_node becomes the parent of in_second_node) or a query
// (lowest common ancestor of in_first_node and in_second_node).
// Result channel (out_valid / out_stall): one out_ancestor word per query,
// 0 when the nodes share no tree, are out of range or sit on a cycle.
// An edge is written in the cycle it is accepted and gives no word.
// A query walks the parent table on two read ports: a depth walk, then
// lift and meet. Each step is the table's registered read followed by the
// compare and update. After reset the table is cleared one entry a cycle,
// all 1024 entries; in_stall stays high meanwhile. Items are taken one at
// a time; a finished result sits in the output register, and the next
// item is accepted while it waits. While out_stall holds a full output
// register, a finished query waits in the walker and new items are
// stalled.
module tree_lowest_common_ancestor
  import lca_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_kind,
  input  logic [ID_W-1:0] in_first_node,
  input  logic [ID_W-1:0] in_second_node,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ID_W-1:0] out_ancestor
);

  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_ancestor_r;
  logic              in_accept;
  logic              edge_ok;
  logic              out_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [ID_W-1:0]   rd_data_a, rd_data_b;
  walk_req_t         wreq;
  walk_stat_t        wstat;

  // Input handshake
  assign in_stall  = clr_active_r || wstat.busy;
  assign in_accept = in_valid && !in_stall;
  assign edge_ok   = (in_second_node != '0) && (in_second_node <= MAX_ID)
                  && (in_first_node <= MAX_ID);

  // Clearing pass after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // Table write: clear sweep or edge word
  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = in_accept && (in_kind == KIND_EDGE) && edge_ok;
      mem_waddr = node_addr(in_second_node);
      mem_wdata = in_first_node;
    end
  end

  lca_parent_mem u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Query walker
  assign out_free    = !out_valid_r || !out_stall;
  assign wreq.start  = in_accept && (in_kind == KIND_QUERY);
  assign wreq.ack    = out_free;
  assign wreq.node_a = in_first_node;
  assign wreq.node_b = in_second_node;

  lca_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (wreq),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .stat      (wstat)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = wstat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && wstat.done) begin
      out_ancestor_r <= wstat.result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;

  // A finished query waits in the walker while the output word is held
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (wstat.done && out_valid_r && out_stall) |=> wstat.done)
    else $error("walker result dropped while output was stalled");

  // Table is never written while a query walks it
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !wstat.busy)
    else $error("parent table written during a query");

  // Clearing pass covers every entry
  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> ($past(clr_addr_r) == LAST_ADDR))
    else $error("clearing pass ended early");

  // Answers are node ids or zero
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ancestor_r <= MAX_ID))
    else $error("ancestor out of range");

endmodule

// ----- hw/rtl/lca_parent_mem.sv -----
// Parent table: one write port, two registered read ports.
module lca_parent_mem
  import lca_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ID_W-1:0]   wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [ID_W-1:0]   rd_data_a,
  output logic [ID_W-1:0]   rd_data_b
);

  logic [ID_W-1:0] mem [MAX_NODES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- hw/rtl/lca_walker.sv -----
// Query sequencer: depth walk, lift and meet over the parent table.
module lca_walker
  import lca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  walk_req_t         req,
  input  logic [ID_W-1:0]   rd_data_a,
  input  logic [ID_W-1:0]   rd_data_b,
  output logic [ADDR_W-1:0] rd_addr_a,
  output logic [ADDR_W-1:0] rd_addr_b,
  output walk_stat_t        stat
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DEPTH_RD = 6'b000010,
    S_DEPTH_EV = 6'b000100,
    S_ALIGN_RD = 6'b001000,
    S_ALIGN_EV = 6'b010000,
    S_DONE     = 6'b100000
  } walk_state_t;

  walk_state_t state_r, state_nxt;

  logic [ID_W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [ID_W-1:0]    ca_r, ca_nxt, cb_r, cb_nxt;
  logic [DEPTH_W-1:0] da_r, da_nxt, db_r, db_nxt;
  logic               fin_a_r, fin_a_nxt, fin_b_r, fin_b_nxt;
  logic [ID_W-1:0]    res_r, res_nxt;
  logic               fail;
  logic               a_ok, b_ok;

  assign a_ok = (req.node_a != '0) && (req.node_a <= MAX_ID);
  assign b_ok = (req.node_b != '0) && (req.node_b <= MAX_ID);

  // Read addresses: cursors during the depth walk, the nodes afterwards
  always_comb begin
    if (state_r == S_DEPTH_RD) begin
      rd_addr_a = node_addr(ca_r);
      rd_addr_b = node_addr(cb_r);
    end else begin
      rd_addr_a = node_addr(a_r);
      rd_addr_b = node_addr(b_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    fin_a_nxt = fin_a_r;
    fin_b_nxt = fin_b_r;
    res_nxt   = res_r;
    fail      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          a_nxt     = req.node_a;
          b_nxt     = req.node_b;
          ca_nxt    = req.node_a;
          cb_nxt    = req.node_b;
          da_nxt    = '0;
          db_nxt    = '0;
          fin_a_nxt = 1'b0;
          fin_b_nxt = 1'b0;
          if (a_ok && b_ok) begin
            state_nxt = S_DEPTH_RD;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DEPTH_RD: begin
        state_nxt = S_DEPTH_EV;
      end
      S_DEPTH_EV: begin
        // walker a
        if (!fin_a_r) begin
          if (rd_data_a == '0) begin
            fin_a_nxt = 1'b1;
          end else if (da_r == MAX_DEPTH) begin
            fail = 1'b1;
          end else begin
            ca_nxt = rd_data_a;
            da_nxt = da_r + DEPTH_W'(1);
          end
        end
        // walker b
        if (!fin_b_r) begin
          if (rd_data_b == '0) begin
            fin_b_nxt = 1'b1;
          end else if (db_r == MAX_DEPTH) begin
            fail = 1'b1;
          end else begin
            cb_nxt = rd_data_b;
            db_nxt = db_r + DEPTH_W'(1);
          end
        end
        if (fail) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else if (fin_a_nxt && fin_b_nxt) begin
          state_nxt = S_ALIGN_RD;
        end else begin
          state_nxt = S_DEPTH_RD;
        end
      end
      S_ALIGN_RD: begin
        state_nxt = S_ALIGN_EV;
      end
      S_ALIGN_EV: begin
        // lift the deeper node, then step both until they meet
        if (da_r > db_r) begin
          a_nxt     = rd_data_a;
          da_nxt    = da_r - DEPTH_W'(1);
          state_nxt = S_ALIGN_RD;
        end else if (db_r > da_r) begin
          b_nxt     = rd_data_b;
          db_nxt    = db_r - DEPTH_W'(1);
          state_nxt = S_ALIGN_RD;
        end else if (a_r == b_r) begin
          res_nxt   = a_r;
          state_nxt = S_DONE;
        end else begin
          a_nxt     = rd_data_a;
          b_nxt     = rd_data_b;
          state_nxt = S_ALIGN_RD;
        end
      end
      S_DONE: begin
        if (req.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    da_r    <= da_nxt;
    db_r    <= db_nxt;
    fin_a_r <= fin_a_nxt;
    fin_b_r <= fin_b_nxt;
    res_r   <= res_nxt;
  end

  assign stat.busy   = (state_r != S_IDLE);
  assign stat.done   = (state_r == S_DONE);
  assign stat.result = res_r;

endmodule

// ----- bench/tb_tree_lowest_common_ancestor.sv -----
// Testbench for the lowest common ancestor block: directed and random words, scoreboard check.
`timescale 1ns / 1ps

module tb_tree_lowest_common_ancestor;
  import lca_pkg::*;

  localparam int IDLE_LIMIT  = 25000;
  localparam int WORD_TARGET = 190;
  localparam int LONG_HOLD   = 500;

  // Parent table copy, ancestor prediction and result compare
  class ancestor_scoreboard;
    logic [ID_W-1:0] parent_of [1:MAX_NODES];
    logic [ID_W-1:0] pending_ancestors [$];
    int errors;

    function new();
      foreach (parent_of[i]) parent_of[i] = '0;
      errors = 0;
    endfunction

    function logic [ID_W-1:0] step_up(input logic [ID_W-1:0] node);
      if (node == '0 || node > MAX_ID) return '0;
      return parent_of[node];
    endfunction

    // Depth below the root; fails when no root is reached (cycle or self-loop)
    function bit find_depth(input logic [ID_W-1:0] node, output int unsigned depth);
      logic [ID_W-1:0] cur;
      int unsigned steps;
      cur = node;
      steps = 0;
      while (step_up(cur) != '0 && steps < MAX_NODES) begin
        cur = step_up(cur);
        steps++;
      end
      depth = steps;
      return step_up(cur) == '0;
    endfunction

    function logic [ID_W-1:0] lowest_ancestor(input logic [ID_W-1:0] node_a,
                                              input logic [ID_W-1:0] node_b);
      logic [ID_W-1:0] a, b;
      int unsigned da, db, guard;
      a = node_a;
      b = node_b;
      if (a == '0 || a > MAX_ID || b == '0 || b > MAX_ID) return '0;
      if (!find_depth(a, da) || !find_depth(b, db)) return '0;
      // lift the deeper node, then climb together
      while (da > db) begin
        a = step_up(a);
        da--;
      end
      while (db > da) begin
        b = step_up(b);
        db--;
      end
      guard = 0;
      while (a != b && guard <= MAX_NODES) begin
        a = step_up(a);
        b = step_up(b);
        guard++;
      end
      return (a == b) ? a : '0;
    endfunction

    // Returns 1 when the word changes state or yields a result
    function bit note_word(input logic kind, input logic [ID_W-1:0] node_a,
                           input logic [ID_W-1:0] node_b);
      if (kind == KIND_QUERY) begin
        pending_ancestors = {pending_ancestors, lowest_ancestor(node_a, node_b)};
        return 1'b1;
      end
      if (node_b != '0 && node_b <= MAX_ID && node_a <= MAX_ID) begin
        parent_of[node_b] = node_a;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_word(input logic [ID_W-1:0] got);
      logic [ID_W-1:0] want;
      if (pending_ancestors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: unexpected ancestor word %0d", got);
        return;
      end
      want = pending_ancestors.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: ancestor expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic            in_kind;
  logic [ID_W-1:0] in_first_node;
  logic [ID_W-1:0] in_second_node;
  logic            out_valid;
  logic            out_stall;
  logic [ID_W-1:0] out_ancestor;

  ancestor_scoreboard sb;
  int  useful_words;
  int  results_seen;
  bit  sender_calm;

  tree_lowest_common_ancestor uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_first_node  (in_first_node),
    .in_second_node (in_second_node),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ancestor   (out_ancestor)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly short, a few long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Offer one word, wait for acceptance, then maybe go idle
  task automatic send_word(input logic kind, input logic [ID_W-1:0] node_a,
                           input logic [ID_W-1:0] node_b);
    int gap;
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_first_node  <= node_a;
    in_second_node <= node_b;
    do @(posedge clk); while (in_stall);
    useful_words += sb.note_word(kind, node_a, node_b);
    gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every predicted ancestor has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_ancestors.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int base, span, nq, r, round;
    logic [ID_W-1:0] a, b, up_node;
    sb = new();
    useful_words = 0;
    sender_calm = 1'b0;
    round = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_EDGE;
    in_first_node  <= '0;
    in_second_node <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, range edges, ignored edges, re-parenting, cycles
    send_word(KIND_QUERY, 11'd1, 11'd1);
    send_word(KIND_QUERY, 11'd1, 11'd2);
    send_word(KIND_EDGE, 11'd1024, 11'd1);
    send_word(KIND_EDGE, 11'd1024, 11'd2);
    send_word(KIND_QUERY, 11'd1, 11'd2);
    send_word(KIND_QUERY, 11'd1024, 11'd1);
    send_word(KIND_EDGE, 11'd5, 11'd0);
    send_word(KIND_EDGE, 11'd5, 11'd2047);
    send_word(KIND_EDGE, 11'd2047, 11'd3);
    send_word(KIND_EDGE, 11'd1025, 11'd3);
    send_word(KIND_QUERY, 11'd3, 11'd1);
    send_word(KIND_EDGE, 11'd1, 11'd2);
    send_word(KIND_QUERY, 11'd2, 11'd1);
    send_word(KIND_EDGE, 11'd0, 11'd2);
    send_word(KIND_QUERY, 11'd2, 11'd1024);
    send_word(KIND_QUERY, 11'd0, 11'd1);
    send_word(KIND_QUERY, 11'd1, 11'd2047);
    send_word(KIND_QUERY, 11'd1025, 11'd1023);
    // self-loop, then a two-node cycle with a child hanging below it
    send_word(KIND_EDGE, 11'd7, 11'd7);
    send_word(KIND_QUERY, 11'd7, 11'd1);
    send_word(KIND_EDGE, 11'd0, 11'd7);
    send_word(KIND_EDGE, 11'd8, 11'd9);
    send_word(KIND_EDGE, 11'd9, 11'd8);
    send_word(KIND_EDGE, 11'd8, 11'd10);
    send_word(KIND_QUERY, 11'd10, 11'd1023);
    send_word(KIND_EDGE, 11'd0, 11'd8);
    drain_results();

    // Random: build a forest in a window of ids, query it, sometimes break it
    while (useful_words < WORD_TARGET) begin
      base = $urandom_range(1, MAX_NODES - 40);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 12);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < span; i++) begin
        up_node = (i == 0 || $urandom_range(0, 9) == 0) ? '0
                  : ID_W'(base + $urandom_range(0, i - 1));
        send_word(KIND_EDGE, up_node, ID_W'(base + i));
      end
      if ($urandom_range(0, 3) == 0)
        send_word(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 2047)),
                  ID_W'($urandom_range(0, 2047)));
      nq = $urandom_range(2, 6);
      for (int q = 0; q < nq; q++) begin
        r = $urandom_range(0, 9);
        a = ID_W'(base + $urandom_range(0, span - 1));
        b = ID_W'(base + $urandom_range(0, span - 1));
        if (r == 9) begin
          a = ID_W'($urandom_range(0, 2047));
          b = ID_W'($urandom_range(0, 2047));
        end else if (r >= 7) begin
          b = ID_W'($urandom_range(1, MAX_NODES));
        end
        send_word(KIND_QUERY, a, b);
      end
      // hang the window root below one of its nodes, query, then repair
      if ($urandom_range(0, 7) == 0) begin
        send_word(KIND_EDGE, ID_W'(base + $urandom_range(0, span - 1)), ID_W'(base));
        send_word(KIND_QUERY, ID_W'(base + $urandom_range(0, span - 1)),
                  ID_W'($urandom_range(1, MAX_NODES)));
        send_word(KIND_EDGE, '0, ID_W'(base));
      end
      round++;
      if (round % 6 == 0) drain_results();
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending_ancestors.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result side: check accepted words, random stalls, one long hold
  initial begin
    int stall_left, calm_left;
    bit calm, long_hold_done;
    stall_left = 0;
    calm_left = 0;
    calm = 1'b0;
    long_hold_done = 1'b0;
    results_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_word(out_ancestor);
        results_seen++;
      end
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = idle_length() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any word accepted on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
